/* rtl/xonf_pkg.sv */
`timescale 1ns / 1ps
// Package for the XON/XOFF receive FIFO: ring geometry, field widths,
// flow request codes and configuration register addresses. No dependencies.
package xonf_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MARK_W = 4;
  localparam int unsigned FILL_W = 4;
  localparam int unsigned FLOW_W = 2;
  localparam int unsigned CMP_W  = (CNT_W > MARK_W) ? CNT_W : MARK_W;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Bytes at or below this value are control characters or space: discard.
  localparam logic [BYTE_W-1:0] PRINT_LIMIT = BYTE_W'(32);

  localparam logic [FLOW_W-1:0] FLOW_NONE = 2'd0;
  localparam logic [FLOW_W-1:0] FLOW_XOFF = 2'd1;
  localparam logic [FLOW_W-1:0] FLOW_XON  = 2'd2;

  localparam logic REQ_RECEIVE = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_UPPER_MARK = 1'b0;
  localparam logic REG_LOWER_MARK = 1'b1;

  localparam logic [MARK_W-1:0] UPPER_MARK_RESET = 4'd4;
  localparam logic [MARK_W-1:0] LOWER_MARK_RESET = 4'd2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

/* rtl/xon_xoff_receive_fifo.sv */
`timescale 1ns / 1ps
// Top level of the XON/XOFF receive FIFO: ring memory, pop/filter sequencer,
// output register and APB-style configuration port. Depends on xonf_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | in        | in_valid / in_stall   | req_type, rx_byte
//  out     | out       | out_valid / out_stall | byte_valid, out_byte, flow_code,
//          |           |                       | overflow, fill_level
//  cfg     | in        | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// A receive stores at the transfer edge, then loads the result. A consume on
// an empty ring goes straight to loading its result; otherwise it pops entries
// until a printable one comes out or the ring empties. The single read port of
// the ring memory reads one entry per cycle, so each filtered byte costs one read.
// One item is in work at a time; the next is taken once the result sits in the
// output register, even while that register waits on out_stall.
// Reset is synchronous; the ring contents stay undefined and need no clearing.
module xon_xoff_receive_fifo
  import xonf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [BYTE_W-1:0]   rx_byte,
  // Output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                byte_valid,
  output logic [BYTE_W-1:0]   out_byte,
  output logic [FLOW_W-1:0]   flow_code,
  output logic                overflow,
  output logic [FILL_W-1:0]   fill_level,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Ring memory: one write port, one registered read port.
  logic [BYTE_W-1:0] ring_store [DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic [1:0]        state;
  ptr_t              rd_ptr;
  ptr_t              rd_ptr_next;
  ptr_t              wr_ptr;
  cnt_t              count;
  logic              xoff_in_force;
  logic              xon_in_force;
  logic [MARK_W-1:0] upper_mark;
  logic [MARK_W-1:0] lower_mark;

  // Result of the item in work, held until the output register is free.
  logic              res_valid;
  logic [BYTE_W-1:0] res_byte;
  logic [FLOW_W-1:0] res_flow;
  logic              res_ovf;

  logic              in_xfer;
  logic              out_free;
  logic              cfg_write;
  logic              full;
  cnt_t              cnt_after;
  cnt_t              cnt_dec;
  logic              printable;
  logic              xoff_req;
  logic              xon_req;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Receive path: a full ring drops the byte, the XOFF check uses the post-store count.
  assign full      = (count == CNT_W'(DEPTH));
  assign cnt_after = full ? count : count + CNT_W'(1);
  assign xoff_req  = (CMP_W'(cnt_after) > CMP_W'(upper_mark)) && !xoff_in_force;

  // Pop path: rdata holds the entry at rd_ptr while in ST_READ.
  assign cnt_dec   = count - CNT_W'(1);
  assign printable = (rdata > PRINT_LIMIT);
  assign xon_req   = (CMP_W'(cnt_dec) < CMP_W'(lower_mark)) && !xon_in_force;

  // The read address follows the next read pointer, so rdata always shows the
  // head entry in the following cycle. Writes happen only on a receive transfer, and
  // the FINISH cycle after it lets the head be read again before any pop.
  always_comb begin
    rd_ptr_next = rd_ptr;
    if (state == ST_READ) begin
      rd_ptr_next = ptr_inc(rd_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && req_type == REQ_RECEIVE && !full) begin
      ring_store[wr_ptr] <= rx_byte;
    end
    rdata <= ring_store[rd_ptr_next];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_mark <= UPPER_MARK_RESET;
      lower_mark <= LOWER_MARK_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_UPPER_MARK: upper_mark <= pwdata[MARK_W-1:0];
        REG_LOWER_MARK: lower_mark <= pwdata[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_UPPER_MARK: prdata = DATA_W'(upper_mark);
      REG_LOWER_MARK: prdata = DATA_W'(lower_mark);
      default:        prdata = '0;
    endcase
  end

  // Sequencer and ring state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      count         <= '0;
      xoff_in_force <= 1'b0;
      xon_in_force  <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            res_valid <= 1'b0;
            res_byte  <= '0;
            res_flow  <= (req_type == REQ_RECEIVE && xoff_req) ? FLOW_XOFF : FLOW_NONE;
            res_ovf   <= (req_type == REQ_RECEIVE) && full;
            if (req_type == REQ_RECEIVE) begin
              if (!full) begin
                wr_ptr <= ptr_inc(wr_ptr);
                count  <= cnt_after;
              end
              if (xoff_req) begin
                xoff_in_force <= 1'b1;
                xon_in_force  <= 1'b0;
              end
              state <= ST_FINISH;
            end else if (count == '0) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // Pop one entry per cycle; drop non-printable bytes.
          rd_ptr <= rd_ptr_next;
          count  <= cnt_dec;
          if (printable) begin
            res_valid <= 1'b1;
            res_byte  <= rdata;
            if (xon_req) begin
              res_flow      <= FLOW_XON;
              xon_in_force  <= 1'b1;
              xoff_in_force <= 1'b0;
            end
            state <= ST_FINISH;
          end else if (cnt_dec == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: load from the held result, clear valid on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      byte_valid <= res_valid;
      out_byte   <= res_byte;
      flow_code  <= res_flow;
      overflow   <= res_ovf;
      fill_level <= FILL_W'(count);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above ring depth");

  a_flow_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot({xoff_in_force, xon_in_force}))
    else $error("XON and XOFF in force together or neither");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> count != '0)
    else $error("pop from an empty ring");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == '0)
    else $error("nonzero byte without delivery");

  a_ovf_no_delivery: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !byte_valid && flow_code != FLOW_XON)
    else $error("overflow flagged on a consume result");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for xon_xoff_receive_fifo: a scripted opening sequence,
// then random receive/consume traffic under several watermark settings.
// Depends on xonf_pkg and the xon_xoff_receive_fifo RTL.
module testbench;
  import xonf_pkg::*;

  // One result transfer, field by field, at the widths of the output ports.
  typedef struct packed {
    logic                byte_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic [FLOW_W-1:0]   flow_code;
    logic                overflow;
    logic [FILL_W-1:0]   fill_level;
  } fifo_outcome_t;

  // One row of the opening script; the outcome is typed in only where
  // has_typed is set, otherwise the row is checked against the predictor.
  typedef struct packed {
    logic                req;
    logic [BYTE_W-1:0]   data;
    logic                has_typed;
    fifo_outcome_t       typed_out;
  } script_row_t;

  localparam int OPENING_LEN    = 20;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 56;
  localparam int SEGMENT_LEN    = 16;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 300000;

  // Opening script, run with the reset marks (upper 4, lower 2).
  localparam script_row_t OPENING_ROWS [OPENING_LEN] = '{
    // consume on an empty ring: nothing delivered, state unchanged
    '{REQ_CONSUME, 8'hFF, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd0}},
    '{REQ_RECEIVE, 8'h00, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd1}},
    '{REQ_RECEIVE, 8'h20, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd2}},
    '{REQ_RECEIVE, 8'h21, 1'b0, '0},
    '{REQ_RECEIVE, 8'hFF, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd4}},
    // count crosses the upper mark: ask for XOFF once
    '{REQ_RECEIVE, 8'h0A, 1'b1, '{1'b0, 8'h00, FLOW_XOFF, 1'b0, 4'd5}},
    '{REQ_RECEIVE, 8'h0D, 1'b0, '0},
    '{REQ_RECEIVE, 8'h1A, 1'b0, '0},
    '{REQ_RECEIVE, 8'h7E, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd8}},
    // full ring: drop the byte, flag overflow, XOFF already in force
    '{REQ_RECEIVE, 8'h55, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b1, 4'd8}},
    '{REQ_RECEIVE, 8'hAA, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b1, 4'd8}},
    // skip the control byte and the space, deliver the first printable one
    '{REQ_CONSUME, 8'h00, 1'b1, '{1'b1, 8'h21, FLOW_NONE, 1'b0, 4'd5}},
    '{REQ_CONSUME, 8'hFF, 1'b0, '0},
    // skip LF, CR, end-of-file; count falls below the lower mark: XON
    '{REQ_CONSUME, 8'h00, 1'b1, '{1'b1, 8'h7E, FLOW_XON, 1'b0, 4'd0}},
    '{REQ_CONSUME, 8'h5A, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd0}},
    '{REQ_RECEIVE, 8'h09, 1'b0, '0},
    '{REQ_RECEIVE, 8'h20, 1'b0, '0},
    // ring drained by filtering: no delivery, no XON check
    '{REQ_CONSUME, 8'h00, 1'b1, '{1'b0, 8'h00, FLOW_NONE, 1'b0, 4'd0}},
    '{REQ_RECEIVE, 8'h80, 1'b0, '0},
    // delivery below the lower mark while XON is already in force
    '{REQ_CONSUME, 8'h00, 1'b1, '{1'b1, 8'h80, FLOW_NONE, 1'b0, 4'd0}}
  };

  // Watermark settings of the first random phases; the rest are drawn.
  localparam logic [MARK_W-1:0] UPPER_PLAN [6] = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd8, 4'd0};
  localparam logic [MARK_W-1:0] LOWER_PLAN [6] = '{4'd0, 4'd8, 4'd15, 4'd6, 4'd0, 4'd15};

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [BYTE_W-1:0]   rx_byte;
  logic                out_valid;
  logic                out_stall;
  logic                byte_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic [FLOW_W-1:0]   flow_code;
  logic                overflow;
  logic [FILL_W-1:0]   fill_level;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predictor copy of the ring, its pointers, flow state and marks.
  logic [BYTE_W-1:0]   ring_copy [DEPTH];
  int                  rd_slot;
  int                  wr_slot;
  int                  stored;
  bit                  xoff_sent;
  bit                  xon_sent;
  logic [MARK_W-1:0]   upper_lim;
  logic [MARK_W-1:0]   lower_lim;

  fifo_outcome_t       outcomes_due [$];
  int                  mismatches;
  int                  cycle_count;
  bit                  in_idle_on;
  bit                  out_idle_on;
  bit                  hold_long;

  xon_xoff_receive_fifo u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_valid (byte_valid),
    .out_byte   (out_byte),
    .flow_code  (flow_code),
    .overflow   (overflow),
    .fill_level (fill_level),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the predicted ring by one transfer and return its outcome.
  function automatic fifo_outcome_t compute_fifo_outcome(input logic req,
                                                         input logic [BYTE_W-1:0] data);
    fifo_outcome_t     o;
    logic [BYTE_W-1:0] popped;
    o = '0;
    if (req == REQ_RECEIVE) begin
      if (stored >= DEPTH) begin
        o.overflow = 1'b1;
      end else begin
        ring_copy[wr_slot] = data;
        wr_slot = (wr_slot + 1) % DEPTH;
        stored++;
      end
      // the XOFF check runs even when the byte was dropped
      if (stored > int'(upper_lim) && !xoff_sent) begin
        o.flow_code = FLOW_XOFF;
        xoff_sent = 1'b1;
        xon_sent = 1'b0;
      end
    end else begin
      // pop until a printable byte comes out or the ring is empty
      while (stored > 0 && !o.byte_valid) begin
        popped = ring_copy[rd_slot];
        rd_slot = (rd_slot + 1) % DEPTH;
        stored--;
        if (popped > PRINT_LIMIT) begin
          o.byte_valid = 1'b1;
          o.out_byte = popped;
        end
      end
      if (o.byte_valid && stored < int'(lower_lim) && !xon_sent) begin
        o.flow_code = FLOW_XON;
        xon_sent = 1'b1;
        xoff_sent = 1'b0;
      end
    end
    o.fill_level = FILL_W'(stored);
    return o;
  endfunction

  // Offer one request, hold it until the transfer, then queue its outcome.
  task automatic offer_item(input logic req, input logic [BYTE_W-1:0] data,
                            input logic has_typed, input fifo_outcome_t typed_out);
    int            gap;
    fifo_outcome_t predicted;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = compute_fifo_outcome(req, data);
    outcomes_due.push_back(has_typed ? typed_out : predicted);
  endtask

  // Drop valid and wait until every outcome has been delivered.
  task automatic settle_fifo();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a watermark register, then read it back in the following access.
  task automatic write_mark(input logic idx, input logic [MARK_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_UPPER_MARK) begin
      upper_lim = value;
    end else begin
      lower_lim = value;
    end
    // keep psel high and go straight into the read setup
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(value)) begin
      report_mismatch(idx == REG_UPPER_MARK ? "upper_mark readback" : "lower_mark readback",
                      prdata, DATA_W'(value));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: draw a stall length per result; once on request, hold off for
  // a long stretch so the block fills up and stalls its input.
  initial begin : drain_side
    int stall_cycles;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        stall_cycles = LONG_HOLD;
        hold_long = 1'b0;
      end else begin
        stall_cycles = out_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest outcome due.
  always @(posedge clk) begin : check_outputs
    fifo_outcome_t due;
    if (!rst && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result transfer with nothing due", 1, 0);
      end else begin
        due = outcomes_due.pop_front();
        if (byte_valid !== due.byte_valid)
          report_mismatch("byte_valid", byte_valid, due.byte_valid);
        if (out_byte !== due.out_byte)
          report_mismatch("out_byte", out_byte, due.out_byte);
        if (flow_code !== due.flow_code)
          report_mismatch("flow_code", flow_code, due.flow_code);
        if (overflow !== due.overflow)
          report_mismatch("overflow", overflow, due.overflow);
        if (fill_level !== due.fill_level)
          report_mismatch("fill_level", fill_level, due.fill_level);
      end
    end
  end

  // Bound the run; a hang ends here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int                i;
    int                p;
    int                k;
    int                recv_pct;
    logic              req;
    logic [BYTE_W-1:0] data;
    logic [MARK_W-1:0] up_set;
    logic [MARK_W-1:0] lo_set;

    // Drive every input to a known value before the first edge.
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_RECEIVE;
    rx_byte  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    mismatches  = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    hold_long   = 1'b0;

    // Predictor reset state.
    for (i = 0; i < DEPTH; i++) ring_copy[i] = '0;
    rd_slot   = 0;
    wr_slot   = 0;
    stored    = 0;
    xoff_sent = 1'b0;
    xon_sent  = 1'b1;
    upper_lim = UPPER_MARK_RESET;
    lower_lim = LOWER_MARK_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the opening script with the reset marks.
    for (i = 0; i < OPENING_LEN; i++) begin
      offer_item(OPENING_ROWS[i].req, OPENING_ROWS[i].data,
                 OPENING_ROWS[i].has_typed, OPENING_ROWS[i].typed_out);
    end
    settle_fifo();

    // Random phases; the ring state carries over from one phase to the next,
    // so a full ring may meet a freshly lowered upper mark.
    recv_pct = 50;
    for (p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        up_set = UPPER_PLAN[p];
        lo_set = LOWER_PLAN[p];
      end else begin
        up_set = MARK_W'($urandom_range(0, 15));
        lo_set = MARK_W'($urandom_range(0, 15));
      end
      write_mark(REG_UPPER_MARK, up_set);
      write_mark(REG_LOWER_MARK, lo_set);
      if (p == 1) hold_long = 1'b1;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Re-draw the traffic mix and idling every segment: fill bursts,
        // drain bursts, balanced runs, and stretches with no gaps at all.
        if (k % SEGMENT_LEN == 0) begin
          case ($urandom_range(0, 2))
            0:       recv_pct = 25;
            1:       recv_pct = 50;
            default: recv_pct = 80;
          endcase
          in_idle_on  = ($urandom_range(0, 2) != 0);
          out_idle_on = ($urandom_range(0, 2) != 0);
        end
        req = ($urandom_range(0, 99) < recv_pct) ? REQ_RECEIVE : REQ_CONSUME;
        case ($urandom_range(0, 3))
          0:       data = BYTE_W'($urandom_range(0, 32));
          1:       data = $urandom_range(0, 1) ? PRINT_LIMIT : PRINT_LIMIT + BYTE_W'(1);
          default: data = BYTE_W'($urandom_range(0, 255));
        endcase
        offer_item(req, data, 1'b0, '0);
      end
      settle_fifo();
    end

    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
